// ===== rtl/core/a2o_pkg.sv =====
// Shared types, constants and table functions for the octant atan2 block.
// No dependencies.
package a2o_pkg;

  localparam int unsigned SECTIONS = 8;
  localparam logic signed [15:0] DEG90  = 16'sd11520;
  localparam logic signed [15:0] DEG180 = 16'sd23040;

  typedef struct packed {
    logic ys;
    logic xs;
    logic le;
    logic zero;
    logic last;
  } a2o_tag_t;

  // {y<0, x<0, |y|<=|x|}
  typedef enum logic [2:0] {
    OCT_PP_STEEP = 3'd0,
    OCT_PP_FLAT  = 3'd1,
    OCT_PN_STEEP = 3'd2,
    OCT_PN_FLAT  = 3'd3,
    OCT_NP_STEEP = 3'd4,
    OCT_NP_FLAT  = 3'd5,
    OCT_NN_STEEP = 3'd6,
    OCT_NN_FLAT  = 3'd7
  } a2o_oct_e;

  // atan(p/8) in 1/128 degree
  function automatic logic [12:0] a2o_lo(input logic [3:0] p);
    logic [12:0] r;
    case (p)
      4'd0:    r = 13'd0;
      4'd1:    r = 13'd912;
      4'd2:    r = 13'd1797;
      4'd3:    r = 13'd2631;
      4'd4:    r = 13'd3400;
      4'd5:    r = 13'd4097;
      4'd6:    r = 13'd4719;
      4'd7:    r = 13'd5272;
      4'd8:    r = 13'd5760;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  // T[p+1] - T[p]; zero past the last section (weight is zero there)
  function automatic logic [9:0] a2o_step(input logic [3:0] p);
    logic [9:0] r;
    case (p)
      4'd0:    r = 10'd912;
      4'd1:    r = 10'd885;
      4'd2:    r = 10'd834;
      4'd3:    r = 10'd769;
      4'd4:    r = 10'd697;
      4'd5:    r = 10'd622;
      4'd6:    r = 10'd553;
      4'd7:    r = 10'd488;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/a2o_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit of min/max per stage.
// Depends on a2o_pkg.
module a2o_div_cell #(
  parameter int unsigned W     = 16,
  parameter int unsigned R     = 16,
  parameter bit          FIRST = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  a2o_pkg::a2o_tag_t tag_i,
  input  logic [W-1:0]      big_i,
  input  logic [W-1:0]      rem_i,
  input  logic [R:0]        quo_i,
  output logic              valid_o,
  output a2o_pkg::a2o_tag_t tag_o,
  output logic [W-1:0]      big_o,
  output logic [W-1:0]      rem_o,
  output logic [R:0]        quo_o
);
  import a2o_pkg::*;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         bit_d;
  logic [W-1:0] rem_d;
  logic [R:0]   quo_d;
  logic         valid_q;
  a2o_tag_t     tag_q;
  logic [W-1:0] big_q;
  logic [W-1:0] rem_q;
  logic [R:0]   quo_q;

  always_comb begin
    trial = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
    diff  = trial - {1'b0, big_i};
    bit_d = trial >= {1'b0, big_i};
    rem_d = bit_d ? diff[W-1:0] : trial[W-1:0];
    quo_d = {quo_i[R-1:0], bit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_i;
    big_q <= big_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign big_o   = big_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

// ===== rtl/core/a2o_interp.sv =====
// Section lookup, linear interpolation and octant fold, two register stages.
// Depends on a2o_pkg.
module a2o_interp #(
  parameter int unsigned R = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  a2o_pkg::a2o_tag_t tag_i,
  input  logic [R:0]        quo_i,
  output logic              valid_o,
  output logic [15:0]       angle_o,
  output logic              last_o
);
  import a2o_pkg::*;

  localparam int unsigned F = R - 3;
  localparam logic [F+10:0] HALF = (F+11)'(1) << (F - 1);

  logic [R:0]      q;
  logic [3:0]      sec;
  logic [F-1:0]    k;
  logic [F+9:0]    prod_d;
  logic            v1_q;
  a2o_tag_t        tag1_q;
  logic [12:0]     lo1_q;
  logic [F+9:0]    prod1_q;
  logic [F+10:0]   sum;
  logic [12:0]     interp;
  logic signed [15:0] res_d;
  logic            v2_q;
  logic [15:0]     angle_q;
  logic            last_q;

  always_comb begin
    q      = tag_i.zero ? '0 : quo_i;
    sec    = q[R:F];
    k      = q[F-1:0];
    prod_d = (F+10)'(a2o_step(sec)) * (F+10)'(k);
  end

  always_comb begin
    sum    = {1'b0, prod1_q} + HALF;
    interp = lo1_q + 13'(sum[F+10:F]);
    case (a2o_oct_e'({tag1_q.ys, tag1_q.xs, tag1_q.le}))
      OCT_PP_STEEP: res_d = DEG90 - $signed({3'b000, interp});
      OCT_PP_FLAT:  res_d = $signed({3'b000, interp});
      OCT_PN_STEEP: res_d = DEG90 + $signed({3'b000, interp});
      OCT_PN_FLAT:  res_d = DEG180 - $signed({3'b000, interp});
      OCT_NP_STEEP: res_d = -DEG90 + $signed({3'b000, interp});
      OCT_NP_FLAT:  res_d = -$signed({3'b000, interp});
      OCT_NN_STEEP: res_d = -DEG90 - $signed({3'b000, interp});
      OCT_NN_FLAT:  res_d = -DEG180 + $signed({3'b000, interp});
      default:      res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q  <= tag_i;
    lo1_q   <= a2o_lo(sec);
    prod1_q <= prod_d;
    angle_q <= res_d;
    last_q  <= tag1_q.last;
  end

  assign valid_o = v2_q;
  assign angle_o = angle_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/core/atan2_octant_table_interp.sv =====
// Top level of the octant atan2: magnitude front stage, division cell chain, interpolator.
// Depends on a2o_pkg, a2o_div_cell, a2o_interp.
//
//   channel   handshake         fields
//   request   start / busy      x_value_i, y_value_i, last_pair_i
//   result    valid_o strobe    angle_deg_o, last_angle_o
//
// One request per clock; busy stays low. Each request passes through
// one front stage, RATIO_BITS + 1 division cells (one quotient bit each),
// and two interpolation stages. Results are strobed for one cycle in order.
// Reset clears only the valid bits along the chain; nothing can stall it.
module atan2_octant_table_interp #(
  parameter int unsigned INPUT_WIDTH = 16,
  parameter int unsigned RATIO_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [INPUT_WIDTH-1:0] x_value_i,
  input  logic [INPUT_WIDTH-1:0] y_value_i,
  input  logic                   last_pair_i,
  output logic                   valid_o,
  output logic [15:0]            angle_deg_o,
  output logic                   last_angle_o
);
  import a2o_pkg::*;

  localparam int unsigned W = INPUT_WIDTH;
  localparam int unsigned R = RATIO_BITS;
  localparam int unsigned N = R + 1;

  logic [W-1:0] ax;
  logic [W-1:0] ay;
  logic         le;
  a2o_tag_t     tag_d;
  logic         v0_q;
  a2o_tag_t     tag0_q;
  logic [W-1:0] big_q;
  logic [W-1:0] small_q;

  logic         v_w   [N+1];
  a2o_tag_t     tag_w [N+1];
  logic [W-1:0] big_w [N+1];
  logic [W-1:0] rem_w [N+1];
  logic [R:0]   quo_w [N+1];

  always_comb begin
    ax = x_value_i[W-1] ? (~x_value_i + W'(1)) : x_value_i;
    ay = y_value_i[W-1] ? (~y_value_i + W'(1)) : y_value_i;
    le = ay <= ax;
    tag_d.ys   = y_value_i[W-1];
    tag_d.xs   = x_value_i[W-1];
    tag_d.le   = le;
    tag_d.zero = (ax == '0) && (ay == '0);
    tag_d.last = last_pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    tag0_q  <= tag_d;
    big_q   <= le ? ax : ay;
    small_q <= le ? ay : ax;
  end

  assign v_w[0]   = v0_q;
  assign tag_w[0] = tag0_q;
  assign big_w[0] = big_q;
  assign rem_w[0] = small_q;
  assign quo_w[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    a2o_div_cell #(
      .W     (W),
      .R     (R),
      .FIRST (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_w[i]),
      .tag_i   (tag_w[i]),
      .big_i   (big_w[i]),
      .rem_i   (rem_w[i]),
      .quo_i   (quo_w[i]),
      .valid_o (v_w[i+1]),
      .tag_o   (tag_w[i+1]),
      .big_o   (big_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .quo_o   (quo_w[i+1])
    );
  end

  a2o_interp #(
    .R (R)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_w[N]),
    .tag_i   (tag_w[N]),
    .quo_i   (quo_w[N]),
    .valid_o (valid_o),
    .angle_o (angle_deg_o),
    .last_o  (last_angle_o)
  );

  assign busy = 1'b0;

endmodule

// ===== rtl/core/a2o_checker.sv =====
// Port-level checks for the octant atan2 block, bound to the top level.
// Depends on atan2_octant_table_interp.
module a2o_checker #(
  parameter int unsigned INPUT_WIDTH = 16,
  parameter int unsigned RATIO_BITS  = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic [INPUT_WIDTH-1:0] x_value_i,
  input logic [INPUT_WIDTH-1:0] y_value_i,
  input logic                   last_pair_i,
  input logic                   valid_o,
  input logic [15:0]            angle_deg_o,
  input logic                   last_angle_o
);

  localparam int unsigned LAT = RATIO_BITS + 4;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT valid_o)
    else $error("request did not produce a result after the pipeline latency");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_angle_o == $past(last_pair_i, LAT)))
    else $error("last flag does not follow its request");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(start && (x_value_i == '0) && (y_value_i == '0), LAT))
      |-> (angle_deg_o == 16'd0))
    else $error("zero vector did not give zero angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(angle_deg_o) <= 16'sd23040 &&
                 $signed(angle_deg_o) >= -16'sd23040))
    else $error("angle outside half-turn range");

endmodule

bind atan2_octant_table_interp a2o_checker #(
  .INPUT_WIDTH (INPUT_WIDTH),
  .RATIO_BITS  (RATIO_BITS)
) u_a2o_checker (.*);
